### rtl/lfps_pkg.sv
// ----------------------------------------------------------------------------
// lfps_pkg
// Shared constants for the line follower PID steering block: field widths,
// register map codes and register reset values.
// ----------------------------------------------------------------------------
package lfps_pkg;

  // Default sizes of the sample fields and the integral accumulator
  localparam int unsigned SampleBitsDefault = 12;
  localparam int unsigned SumBitsDefault    = 24;

  // Fixed point format of the gains and the drive levels
  localparam int unsigned GainW    = 16;
  localparam int unsigned FracBits = 8;
  localparam int unsigned DriveW   = 8;
  localparam int unsigned DriveTop = 255 * (2 ** FracBits);

  // Configuration port
  localparam int unsigned AddrW  = 5;
  localparam int unsigned DataW  = 32;
  localparam int unsigned RegIdW = 3;

  localparam logic [RegIdW-1:0] RegGainP  = 3'd0;
  localparam logic [RegIdW-1:0] RegGainI  = 3'd1;
  localparam logic [RegIdW-1:0] RegGainD  = 3'd2;
  localparam logic [RegIdW-1:0] RegBase   = 3'd3;
  localparam logic [RegIdW-1:0] RegEnable = 3'd4;

  // Register reset values
  localparam logic signed [GainW-1:0] GainPReset = 16'sd128;
  localparam logic signed [GainW-1:0] GainIReset = 16'sd0;
  localparam logic signed [GainW-1:0] GainDReset = 16'sd26;
  localparam logic [DriveW-1:0]       BaseReset  = 8'd150;
  localparam logic                    EnableReset = 1'b1;

endpackage

### rtl/line_follow_pid_steering.sv
// Pipeline: an accepted input item passes the error/integral stage, multiply stage
//   and sum and clamp stage registers before its result item is valid.
// Throughput: one item per cycle unless out_ready_i holds the output; the three gain
//   products are formed in parallel in one registered stage, so nothing loops back inside an item.
// Reset: rst_ni clears the pipeline valids, the stored error and the integral,
//   and loads the register defaults (gains 128/0/26, base 150, drive on).
// ----------------------------------------------------------------------------
// line_follow_pid_steering
// PID steering for a two sensor line follower. Forms the sensor error, a
// saturating integral and a derivative, weights them with signed 8.8 gains
// and splits the steering term into clamped left and right motor duties.
// ----------------------------------------------------------------------------
module line_follow_pid_steering
  import lfps_pkg::*;
#(
  parameter int unsigned SAMPLE_BITS = SampleBitsDefault,
  parameter int unsigned SUM_BITS    = SumBitsDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,

  // Configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [AddrW-1:0]              paddr,
  input  logic [DataW-1:0]              pwdata,
  output logic [DataW-1:0]              prdata,
  output logic                          pready,

  // Sample input
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [SAMPLE_BITS-1:0]        left_sample_i,
  input  logic [SAMPLE_BITS-1:0]        right_sample_i,

  // Drive output
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [DriveW-1:0]             left_drive_o,
  output logic [DriveW-1:0]             right_drive_o,
  output logic signed [SAMPLE_BITS:0]   tracking_error_o,
  output logic                          stopped_o
);

  localparam int unsigned ErrW    = SAMPLE_BITS + 1;
  localparam int unsigned DerivW  = ErrW + 1;
  localparam int unsigned ProdPW  = GainW + ErrW;
  localparam int unsigned ProdIW  = GainW + SUM_BITS;
  localparam int unsigned ProdDW  = GainW + DerivW;
  localparam int unsigned ProdMaxW = (ProdIW > ProdDW) ? ProdIW : ProdDW;
  localparam int unsigned SteerW  = ProdMaxW + 2;
  localparam int unsigned LevelW  = SteerW + 1;

  localparam logic signed [SUM_BITS-1:0] SumMax = {1'b0, {(SUM_BITS-1){1'b1}}};
  localparam logic signed [SUM_BITS-1:0] SumMin = {1'b1, {(SUM_BITS-1){1'b0}}};

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic signed [GainW-1:0] gain_p_q, gain_i_q, gain_d_q;
  logic [DriveW-1:0]       base_speed_q;
  logic                    drive_enable_q;
  logic                    cfg_write;
  logic [RegIdW-1:0]       reg_id;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign reg_id    = paddr[AddrW-1:2];

  // Write the addressed register; ignore unmapped addresses
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_p_q       <= GainPReset;
      gain_i_q       <= GainIReset;
      gain_d_q       <= GainDReset;
      base_speed_q   <= BaseReset;
      drive_enable_q <= EnableReset;
    end else if (cfg_write) begin
      unique case (reg_id)
        RegGainP:  gain_p_q       <= pwdata[GainW-1:0];
        RegGainI:  gain_i_q       <= pwdata[GainW-1:0];
        RegGainD:  gain_d_q       <= pwdata[GainW-1:0];
        RegBase:   base_speed_q   <= pwdata[DriveW-1:0];
        RegEnable: drive_enable_q <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Read back the addressed register
  always_comb begin
    unique case (reg_id)
      RegGainP:  prdata = {{(DataW-GainW){1'b0}}, gain_p_q};
      RegGainI:  prdata = {{(DataW-GainW){1'b0}}, gain_i_q};
      RegGainD:  prdata = {{(DataW-GainW){1'b0}}, gain_d_q};
      RegBase:   prdata = {{(DataW-DriveW){1'b0}}, base_speed_q};
      RegEnable: prdata = {{(DataW-1){1'b0}}, drive_enable_q};
      default:   prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Pipeline flow control: each stage moves when the next one has room
  // --------------------------------------------------------------------------
  logic s1_valid_q, s2_valid_q, out_valid_q;
  logic s1_ready, s2_ready, s3_ready;
  logic in_fire;

  assign s3_ready   = !out_valid_q || out_ready_i;
  assign s2_ready   = !s2_valid_q || s3_ready;
  assign s1_ready   = !s1_valid_q || s2_ready;
  assign in_ready_o = s1_ready;
  assign in_fire    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_ready) s1_valid_q  <= in_valid_i;
      if (s2_ready) s2_valid_q  <= s1_valid_q;
      if (s3_ready) out_valid_q <= s2_valid_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: error, saturating integral, derivative
  // --------------------------------------------------------------------------
  logic signed [ErrW-1:0]     err_w;
  logic        [SUM_BITS:0]   sum_wide;
  logic signed [SUM_BITS-1:0] error_sum_d, error_sum_q;
  logic signed [ErrW-1:0]     last_error_q;
  logic signed [DerivW-1:0]   deriv_w;
  logic signed [ErrW-1:0]     s1_err_q;
  logic signed [DerivW-1:0]   s1_deriv_q;
  logic signed [SUM_BITS-1:0] s1_sum_q;

  assign err_w    = $signed({1'b0, left_sample_i}) - $signed({1'b0, right_sample_i});
  assign sum_wide = {error_sum_q[SUM_BITS-1], error_sum_q}
                  + {{(SUM_BITS+1-ErrW){err_w[ErrW-1]}}, err_w};
  assign deriv_w  = {err_w[ErrW-1], err_w} - {last_error_q[ErrW-1], last_error_q};

  // Clip the integral at the signed limits when the add overflows
  always_comb begin
    if (sum_wide[SUM_BITS] != sum_wide[SUM_BITS-1]) begin
      error_sum_d = sum_wide[SUM_BITS] ? SumMin : SumMax;
    end else begin
      error_sum_d = sum_wide[SUM_BITS-1:0];
    end
  end

  // Update the controller state once per accepted item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      error_sum_q  <= '0;
      last_error_q <= '0;
    end else if (in_fire) begin
      error_sum_q  <= error_sum_d;
      last_error_q <= err_w;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_err_q   <= err_w;
      s1_deriv_q <= deriv_w;
      s1_sum_q   <= error_sum_d;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: gain products
  // --------------------------------------------------------------------------
  logic signed [ProdPW-1:0] s2_prod_p_q;
  logic signed [ProdIW-1:0] s2_prod_i_q;
  logic signed [ProdDW-1:0] s2_prod_d_q;
  logic signed [ErrW-1:0]   s2_err_q;

  always_ff @(posedge clk_i) begin
    if (s1_valid_q && s2_ready) begin
      s2_prod_p_q <= gain_p_q * s1_err_q;
      s2_prod_i_q <= gain_i_q * s1_sum_q;
      s2_prod_d_q <= gain_d_q * s1_deriv_q;
      s2_err_q    <= s1_err_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: steering sum, drive levels, clamp
  // --------------------------------------------------------------------------
  logic signed [SteerW-1:0] steer_w;
  logic signed [LevelW-1:0] base_fixed_w, left_level_w, right_level_w;
  logic [DriveW-1:0]        left_drive_q, right_drive_q;
  logic signed [ErrW-1:0]   tracking_error_q;
  logic                     stopped_q;

  // Clamp an 8.8 level to 0..255 and drop the fraction
  function automatic logic [DriveW-1:0] drive_clamp(logic signed [LevelW-1:0] level);
    logic [DriveW-1:0] duty;
    if (level <= $signed(LevelW'(0))) begin
      duty = '0;
    end else if (level >= $signed(LevelW'(DriveTop))) begin
      duty = {DriveW{1'b1}};
    end else begin
      duty = level[FracBits +: DriveW];
    end
    return duty;
  endfunction

  assign steer_w      = SteerW'(s2_prod_p_q) + SteerW'(s2_prod_i_q) + SteerW'(s2_prod_d_q);
  assign base_fixed_w = $signed(LevelW'({base_speed_q, {FracBits{1'b0}}}));
  assign left_level_w  = base_fixed_w - LevelW'(steer_w);
  assign right_level_w = base_fixed_w + LevelW'(steer_w);

  // Force both drives off when the drive is disabled
  always_ff @(posedge clk_i) begin
    if (s2_valid_q && s3_ready) begin
      left_drive_q     <= drive_enable_q ? drive_clamp(left_level_w)  : '0;
      right_drive_q    <= drive_enable_q ? drive_clamp(right_level_w) : '0;
      stopped_q        <= !drive_enable_q;
      tracking_error_q <= s2_err_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign left_drive_o     = left_drive_q;
  assign right_drive_o    = right_drive_q;
  assign tracking_error_o = tracking_error_q;
  assign stopped_o        = stopped_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_stopped_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && stopped_o |-> left_drive_o == '0 && right_drive_o == '0)
    else $error("stopped item carries a nonzero drive");

  a_sum_holds_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && error_sum_q == SumMax && !err_w[ErrW-1] |=> error_sum_q == SumMax)
    else $error("integral left its upper limit on a nonnegative error");

  a_sum_holds_min: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && error_sum_q == SumMin && err_w[ErrW-1] |=> error_sum_q == SumMin)
    else $error("integral left its lower limit on a negative error");

  a_last_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> last_error_q == s1_err_q && s1_sum_q == error_sum_q)
    else $error("stored error or integral differs from the staged item");

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> s1_valid_q && s2_valid_q && out_valid_q && !out_ready_i)
    else $error("input stalled while the pipeline has room");

endmodule

### sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for line_follow_pid_steering. Sample pairs go in over a
// valid/ready channel, gains and base level go in over the register port. An
// in-bench PID model predicts left/right drive, tracking error and the stop
// flag for every accepted item, and each returned item is compared in order.
// Covers defaults, clamping, drive disable, ignored register slots, extreme
// gains, a wide integral swing through zero both ways, a long output stall
// and random traffic over several register settings.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import lfps_pkg::*;

  localparam int unsigned SampleBits = SampleBitsDefault;
  localparam int unsigned SumBits    = SumBitsDefault;
  localparam int unsigned ErrW       = SampleBits + 1;
  localparam int          SampleMax  = (1 << SampleBits) - 1;
  localparam longint      SumMax     = (longint'(1) <<< (SumBits - 1)) - 1;
  localparam longint      SumMin     = -SumMax - 1;
  localparam longint      SwingLevel = 280000;

  localparam int ClkPeriod    = 4;
  localparam int SettleCycles = 8;       // pipeline is 3 deep, leave margin
  localparam int DrainLimit   = 200000;
  localparam int HoldCycles   = 150;
  localparam int PhaseItems   = 90;
  localparam int RandPhases   = 10;
  localparam longint TimeoutNs = 4000000;

  typedef enum int {RxAlways, RxRandom, RxPattern, RxHeavy} rx_mode_e;

  typedef struct {
    logic [DriveW-1:0]      left_drive;
    logic [DriveW-1:0]      right_drive;
    logic signed [ErrW-1:0] tracking_error;
    logic                   stopped;
  } drive_result_t;

  // Clock, reset and block inputs, all known from time zero
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic             psel    = 1'b0;
  logic             penable = 1'b0;
  logic             pwrite  = 1'b0;
  logic [AddrW-1:0] paddr   = '0;
  logic [DataW-1:0] pwdata  = '0;
  logic [DataW-1:0] prdata;
  logic             pready;

  logic                  in_valid_i     = 1'b0;
  logic                  in_ready_o;
  logic [SampleBits-1:0] left_sample_i  = '0;
  logic [SampleBits-1:0] right_sample_i = '0;

  logic                     out_valid_o;
  logic                     out_ready_i = 1'b0;
  logic [DriveW-1:0]        left_drive_o;
  logic [DriveW-1:0]        right_drive_o;
  logic signed [SampleBits:0] tracking_error_o;
  logic                     stopped_o;

  // Model copy of the registers and the controller state
  logic signed [GainW-1:0] cfg_gain_p = GainPReset;
  logic signed [GainW-1:0] cfg_gain_i = GainIReset;
  logic signed [GainW-1:0] cfg_gain_d = GainDReset;
  logic [DriveW-1:0]       cfg_base   = BaseReset;
  logic                    cfg_enable = EnableReset;
  logic signed [ErrW-1:0]  prev_error = '0;
  longint                  err_sum    = 0;

  drive_result_t expected_drive_q[$];
  int            mismatches = 0;

  // Sender pacing and receiver stall controls
  int       tx_gap_max    = 0;
  int       tx_burst_left = 0;
  rx_mode_e rx_mode       = RxAlways;
  int       hold_req      = 0;
  int       hold_seen     = 0;
  int       hold_left     = 0;
  int       rx_phase      = 0;

  line_follow_pid_steering #(
    .SAMPLE_BITS(SampleBits),
    .SUM_BITS   (SumBits)
  ) DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .left_sample_i   (left_sample_i),
    .right_sample_i  (right_sample_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .left_drive_o    (left_drive_o),
    .right_drive_o   (right_drive_o),
    .tracking_error_o(tracking_error_o),
    .stopped_o       (stopped_o)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // Clamp an 8.8 drive level to 0..255 and drop the fraction
  function automatic logic [DriveW-1:0] drive_level(input longint level_fx);
    if (level_fx <= 0) return '0;
    if (level_fx >= longint'(DriveTop)) return {DriveW{1'b1}};
    return level_fx[FracBits +: DriveW];
  endfunction

  // Advance the PID state by one sample pair and return the drive item
  function automatic drive_result_t predict_steering(input logic [SampleBits-1:0] left_s,
                                                     input logic [SampleBits-1:0] right_s);
    longint        err;
    longint        deriv;
    longint        steer;
    longint        base_fx;
    drive_result_t res;
    err     = longint'({1'b0, left_s}) - longint'({1'b0, right_s});
    err_sum = err_sum + err;
    if (err_sum > SumMax) err_sum = SumMax;
    if (err_sum < SumMin) err_sum = SumMin;
    deriv = err - longint'(prev_error);
    steer = longint'(cfg_gain_p) * err + longint'(cfg_gain_i) * err_sum
          + longint'(cfg_gain_d) * deriv;
    prev_error = err[ErrW-1:0];
    base_fx = longint'({1'b0, cfg_base}) <<< FracBits;
    res.tracking_error = err[ErrW-1:0];
    if (cfg_enable) begin
      res.left_drive  = drive_level(base_fx - steer);
      res.right_drive = drive_level(base_fx + steer);
      res.stopped     = 1'b0;
    end else begin
      res.left_drive  = '0;
      res.right_drive = '0;
      res.stopped     = 1'b1;
    end
    return res;
  endfunction

  // Receiver: a stall pattern per mode, plus a counted long hold on request
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      rx_phase <= rx_phase + 1;
      if (hold_seen != hold_req) begin
        hold_seen   <= hold_req;
        hold_left   <= HoldCycles;
        out_ready_i <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left   <= hold_left - 1;
        out_ready_i <= 1'b0;
      end else begin
        case (rx_mode)
          RxAlways:  out_ready_i <= 1'b1;
          RxRandom:  out_ready_i <= ($urandom_range(3, 0) != 0);
          RxPattern: out_ready_i <= ((rx_phase % 7) < 4);
          default:   out_ready_i <= ($urandom_range(9, 0) < 3);
        endcase
      end
    end
  end

  // Compare each returned item with the oldest prediction
  always @(posedge clk_i) begin
    drive_result_t exp_res;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_drive_q.size() == 0) begin
        $error("unexpected result item: left_drive %0d right_drive %0d error %0d",
               left_drive_o, right_drive_o, tracking_error_o);
        mismatches++;
      end else begin
        exp_res = expected_drive_q.pop_front();
        if (left_drive_o !== exp_res.left_drive) begin
          $error("left_drive: expected %0d, actual %0d", exp_res.left_drive, left_drive_o);
          mismatches++;
        end
        if (right_drive_o !== exp_res.right_drive) begin
          $error("right_drive: expected %0d, actual %0d", exp_res.right_drive, right_drive_o);
          mismatches++;
        end
        if (tracking_error_o !== exp_res.tracking_error) begin
          $error("tracking_error: expected %0d, actual %0d",
                 exp_res.tracking_error, tracking_error_o);
          mismatches++;
        end
        if (stopped_o !== exp_res.stopped) begin
          $error("stopped: expected %0d, actual %0d", exp_res.stopped, stopped_o);
          mismatches++;
        end
      end
    end
  end

  // Offer one sample pair, hold it until accepted, then predict its item
  task automatic send_sample(input logic [SampleBits-1:0] left_s,
                             input logic [SampleBits-1:0] right_s);
    in_valid_i     <= 1'b1;
    left_sample_i  <= left_s;
    right_sample_i <= right_s;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    expected_drive_q.push_back(predict_steering(left_s, right_s));
  endtask

  // Send one pair, then drop valid for a gap when the current burst ends
  task automatic offer_pair(input int left_v, input int right_v);
    int gap;
    send_sample(SampleBits'(left_v), SampleBits'(right_v));
    if (tx_burst_left > 0) begin
      tx_burst_left--;
    end else begin
      gap = (tx_gap_max == 0) ? 0 : $urandom_range(tx_gap_max, 0);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      tx_burst_left = $urandom_range(20, 1);
    end
  endtask

  // Drop valid and wait until every predicted item has come back
  task automatic wait_drained();
    int waited;
    waited = 0;
    in_valid_i <= 1'b0;
    while (expected_drive_q.size() != 0 && waited < DrainLimit) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Register write: setup cycle, then access cycle; leaves the select high
  task automatic cfg_write(input logic [RegIdW-1:0] idx, input logic [DataW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    case (idx)
      RegGainP:  cfg_gain_p = value[GainW-1:0];
      RegGainI:  cfg_gain_i = value[GainW-1:0];
      RegGainD:  cfg_gain_d = value[GainW-1:0];
      RegBase:   cfg_base   = value[DriveW-1:0];
      RegEnable: cfg_enable = value[0];
      default: ;
    endcase
  endtask

  task automatic cfg_release();
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  // Drain, then write all five registers with junk in the unused upper bits
  task automatic set_config(input logic signed [GainW-1:0] gp,
                            input logic signed [GainW-1:0] gi,
                            input logic signed [GainW-1:0] gd,
                            input logic [DriveW-1:0] base,
                            input logic en);
    logic [DataW-1:0] junk;
    wait_drained();
    junk = $urandom();
    cfg_write(RegGainP, {junk[DataW-1:GainW], gp});
    junk = $urandom();
    cfg_write(RegGainI, {junk[DataW-1:GainW], gi});
    junk = $urandom();
    cfg_write(RegGainD, {junk[DataW-1:GainW], gd});
    junk = $urandom();
    cfg_write(RegBase, {junk[DataW-1:DriveW], base});
    junk = $urandom();
    cfg_write(RegEnable, {junk[DataW-1:1], en});
    cfg_release();
  endtask

  function automatic int rand_gain(input int span);
    return int'($urandom_range(2 * span, 0)) - span;
  endfunction

  // Register defaults straight out of reset
  task automatic test_reset_defaults();
    offer_pair(0, 0);
    offer_pair(SampleMax, 0);
    offer_pair(0, SampleMax);
    offer_pair(SampleMax, SampleMax);
    offer_pair(100, 90);
  endtask

  // Fraction drop, clamp at both ends, base at its extremes
  task automatic test_drive_clamp();
    set_config(16'sd77, 16'sd0, 16'sd0, 8'd128, 1'b1);
    offer_pair(1000, 873);
    offer_pair(873, 1000);
    offer_pair(3000, 2872);
    offer_pair(0, 600);
    offer_pair(600, 0);
    set_config(16'sd0, 16'sd0, 16'sd0, 8'd255, 1'b1);
    offer_pair(5, 5);
    set_config(16'sd0, 16'sd0, 16'sd0, 8'd0, 1'b1);
    offer_pair(5, 5);
  endtask

  // Drive off: zero outputs, stop flag, error still reported
  task automatic test_drive_disabled();
    set_config(16'sd128, 16'sd0, 16'sd26, 8'd150, 1'b0);
    offer_pair(SampleMax, 0);
    offer_pair(0, SampleMax);
    offer_pair(2000, 2000);
  endtask

  // Writes past the last register must change nothing
  task automatic test_unused_registers();
    set_config(16'sd200, 16'sd0, -16'sd100, 8'd90, 1'b1);
    for (int idx = RegEnable + 1; idx < (1 << RegIdW); idx++)
      cfg_write(RegIdW'(idx), $urandom());
    cfg_release();
    offer_pair(2500, 2100);
    offer_pair(1200, 3900);
  endtask

  // Most negative and most positive gains
  task automatic test_gain_extremes();
    set_config(16'sh8000, 16'sd0, 16'sh7FFF, 8'd128, 1'b1);
    offer_pair(2048, 2047);
    offer_pair(2047, 2048);
    set_config(16'sh7FFF, 16'sd0, 16'sh8000, 8'd128, 1'b1);
    offer_pair(2049, 2048);
    offer_pair(2048, 2048);
  endtask

  // Swing the integral far out on both sides and back through the small window
  task automatic test_integral_swing();
    int r;
    set_config(16'sd0, 16'sd1, 16'sd0, 8'd128, 1'b1);
    rx_mode    = RxRandom;
    tx_gap_max = 2;
    // climb well above zero
    while (err_sum < SwingLevel)
      offer_pair(SampleMax - $urandom_range(3, 0), $urandom_range(3, 0));
    // come down fast, then cross the window in small steps
    while (err_sum > 40000)
      offer_pair($urandom_range(3, 0), SampleMax - $urandom_range(3, 0));
    while (err_sum > -40000) begin
      r = $urandom_range(SampleMax, 1500);
      offer_pair(r - $urandom_range(1500, 200), r);
    end
    // go as far below zero
    while (err_sum > -SwingLevel)
      offer_pair($urandom_range(3, 0), SampleMax - $urandom_range(3, 0));
    // climb back and land exactly on zero
    while (err_sum < -40000)
      offer_pair(SampleMax - $urandom_range(3, 0), $urandom_range(3, 0));
    while (err_sum < -SampleMax) begin
      r = $urandom_range(SampleMax, 1500);
      offer_pair(r, r - $urandom_range(1500, 200));
    end
    offer_pair(int'(-err_sum), 0);
  endtask

  // Hold the output off for a long stretch while items keep coming
  task automatic test_input_stall();
    set_config(16'sd100, 16'sd0, 16'sd40, 8'd128, 1'b1);
    rx_mode    = RxAlways;
    tx_gap_max = 0;
    hold_req++;
    repeat (60) offer_pair($urandom_range(SampleMax, 0), $urandom_range(SampleMax, 0));
  endtask

  // Random traffic across several register settings and pacing modes
  task automatic test_random_traffic();
    int pick;
    int l;
    int r;
    for (int ph = 0; ph < RandPhases; ph++) begin
      case (ph)
        0: set_config(16'sh7FFF, 16'sd0, 16'sh8000, 8'd255, 1'b1);
        1: set_config(16'sh8000, 16'sd0, 16'sh7FFF, 8'd0, 1'b1);
        2: set_config(GainW'($urandom()), GainW'($urandom()), GainW'($urandom()),
                      DriveW'($urandom()), 1'b0);
        3: set_config(16'sd0, 16'sh7FFF, 16'sd0, DriveW'($urandom()), 1'b1);
        default: set_config(GainW'(rand_gain(600)), GainW'(rand_gain(3)),
                            GainW'(rand_gain(600)), DriveW'($urandom()), 1'b1);
      endcase
      rx_mode    = rx_mode_e'(ph % 4);
      tx_gap_max = (ph % 3 == 0) ? 0 : 6;
      for (int n = 0; n < PhaseItems; n++) begin
        pick = $urandom_range(9, 0);
        if (pick < 5) begin
          // near the line: the error stays within 300 either way
          r = $urandom_range(SampleMax, 0);
          l = r + int'($urandom_range(600, 0)) - 300;
          if (l < 0) l = 0;
          if (l > SampleMax) l = SampleMax;
        end else if (pick < 6) begin
          l = $urandom_range(1, 0) ? SampleMax : 0;
          r = $urandom_range(1, 0) ? SampleMax : 0;
        end else begin
          l = $urandom_range(SampleMax, 0);
          r = $urandom_range(SampleMax, 0);
        end
        offer_pair(l, r);
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_drive_clamp();
    test_drive_disabled();
    test_unused_registers();
    test_gain_extremes();
    test_integral_swing();
    test_input_stall();
    test_random_traffic();

    wait_drained();
    if (expected_drive_q.size() != 0) begin
      $error("result items missing at end: %0d", expected_drive_q.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("PASS line_follow_pid_steering");
    end else begin
      $display("FAIL line_follow_pid_steering");
    end
    $finish;
  end

  // Abort a hung run
  initial begin
    #(TimeoutNs);
    $display("FAIL line_follow_pid_steering");
    $finish;
  end

endmodule
